[src/wlba_pkg.sv]
`default_nettype none

package wlba_pkg;

   // field widths fixed by the table format
   localparam int BLOCK_W  = 12;
   localparam int STATUS_W = 3;
   localparam int MARK_W   = 3;
   localparam int ERASE_W  = 32;
   localparam int COUNT_W  = 13;
   localparam int ENTRY_W  = STATUS_W + MARK_W + ERASE_W;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_ALLOC = 2'd2;

   // block status codes
   localparam logic [STATUS_W-1:0] ST_FREE        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_USER_ALLOC  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_USER_CUR    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INDEX_ALLOC = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INDEX_CUR   = 3'd4;

   // erase mark codes
   localparam logic [MARK_W-1:0] MARK_NONE     = 3'd0;
   localparam logic [MARK_W-1:0] MARK_PENDING  = 3'd1;
   localparam logic [MARK_W-1:0] MARK_USER     = 3'd2;
   localparam logic [MARK_W-1:0] MARK_INDEX    = 3'd4;
   localparam logic [MARK_W-1:0] MARK_RESERVED = 3'd5;

   // blocks_in_use after reset
   localparam logic [COUNT_W-1:0] BLOCKS_IN_USE_RESET = 13'd4096;

   typedef struct packed {
      logic [1:0]          mode;
      logic [BLOCK_W-1:0]  block_index;
      logic [STATUS_W-1:0] entry_status;
      logic [MARK_W-1:0]   entry_mark;
      logic [ERASE_W-1:0]  entry_erases;
      logic                index_kind;
   } req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  result_block;
      logic [STATUS_W-1:0] result_status;
      logic [MARK_W-1:0]   result_mark;
      logic [ERASE_W-1:0]  result_erases;
      logic                found;
      logic [COUNT_W-1:0]  erases_done;
      logic [ERASE_W-1:0]  peak_erases;
   } rsp_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MARK_W-1:0]   mark;
      logic [ERASE_W-1:0]  erases;
   } entry_type;

   typedef enum logic [1:0] {
      RSP_NULL,
      RSP_WRITE,
      RSP_READ,
      RSP_ALLOC
   } rsp_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        load;
      logic        write_item;
      logic        read_issue;
      logic        scan_issue;
      logic        finish_best;
      logic        prev_issue;
      logic        prev_write;
      logic        best_write;
      logic        emit;
      rsp_sel_type rsp_sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_end;
      logic have;
      logic prev_valid;
   } stat_type;

endpackage

`default_nettype wire

[src/wlba_ram.sv]
`default_nettype none

module wlba_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[src/wlba_ctrl.sv]
`default_nettype none

module wlba_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [1:0]          req_mode,
   input  wire wlba_pkg::stat_type  stat,
   output wlba_pkg::cmd_type        cmd,
   output logic                     busy,
   output logic                     rsp_valid
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRITE,
      S_READ_ISSUE,
      S_READ_DATA,
      S_NULL,
      S_SCAN,
      S_DECIDE,
      S_PREV_WR,
      S_BEST_WR
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   // command decode and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_mode)
                  wlba_pkg::MODE_WRITE: state_in = S_WRITE;
                  wlba_pkg::MODE_READ:  state_in = S_READ_ISSUE;
                  wlba_pkg::MODE_ALLOC: state_in = S_SCAN;
                  default:              state_in = S_NULL;
               endcase
            end
         end
         S_WRITE: begin
            cmd.write_item = 1'b1;
            cmd.emit       = 1'b1;
            cmd.rsp_sel    = wlba_pkg::RSP_WRITE;
            state_in       = S_IDLE;
         end
         S_READ_ISSUE: begin
            cmd.read_issue = 1'b1;
            state_in       = S_READ_DATA;
         end
         S_READ_DATA: begin
            cmd.emit    = 1'b1;
            cmd.rsp_sel = wlba_pkg::RSP_READ;
            state_in    = S_IDLE;
         end
         S_NULL: begin
            cmd.emit    = 1'b1;
            cmd.rsp_sel = wlba_pkg::RSP_NULL;
            state_in    = S_IDLE;
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               state_in = S_DECIDE;
            end else begin
               cmd.scan_issue = 1'b1;
            end
         end
         S_DECIDE: begin
            if (!stat.have) begin
               cmd.emit    = 1'b1;
               cmd.rsp_sel = wlba_pkg::RSP_NULL;
               state_in    = S_IDLE;
            end else begin
               cmd.finish_best = 1'b1;
               if (stat.prev_valid) begin
                  cmd.prev_issue = 1'b1;
                  state_in       = S_PREV_WR;
               end else begin
                  state_in = S_BEST_WR;
               end
            end
         end
         S_PREV_WR: begin
            cmd.prev_write = 1'b1;
            state_in       = S_BEST_WR;
         end
         S_BEST_WR: begin
            cmd.best_write = 1'b1;
            cmd.emit       = 1'b1;
            cmd.rsp_sel    = wlba_pkg::RSP_ALLOC;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[src/wlba_dpath.sv]
`default_nettype none

module wlba_dpath #(
   parameter int MAX_BLOCKS = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire wlba_pkg::req_type                    req_payload,
   input  wire logic                                 csr_we,
   input  wire logic [wlba_pkg::COUNT_W-1:0]         csr_wdata,
   input  wire wlba_pkg::cmd_type                    cmd,
   output wlba_pkg::stat_type                        stat,
   output wlba_pkg::rsp_type                         rsp_payload
);

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int IW = (AW + 1 > wlba_pkg::COUNT_W) ? AW + 1 : wlba_pkg::COUNT_W;

   wlba_pkg::req_type                  req_ff, req_in;
   logic [wlba_pkg::COUNT_W-1:0]       csr_ff;
   logic [IW-1:0]                      limit_ff, limit_in;
   logic [IW-1:0]                      scan_addr_ff, scan_addr_in;
   logic                               proc_valid_ff;
   logic [AW-1:0]                      proc_addr_ff;
   logic                               have_ff, have_in;
   logic [AW-1:0]                      best_addr_ff, best_addr_in;
   logic [wlba_pkg::ERASE_W-1:0]       best_erases_ff, best_erases_in;
   logic [wlba_pkg::MARK_W-1:0]        best_mark_ff, best_mark_in;
   logic [wlba_pkg::COUNT_W-1:0]       done_ff, done_in;
   logic [wlba_pkg::ERASE_W-1:0]       peak_ff, peak_in;
   logic [AW-1:0]                      user_cur_ff, user_cur_in;
   logic                               user_cur_valid_ff, user_cur_valid_in;
   logic [AW-1:0]                      index_cur_ff, index_cur_in;
   logic                               index_cur_valid_ff, index_cur_valid_in;
   wlba_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                               ram_we;
   logic [AW-1:0]                      ram_waddr;
   wlba_pkg::entry_type                ram_wentry;
   logic [AW-1:0]                      ram_raddr;
   logic [wlba_pkg::ENTRY_W-1:0]       ram_rdata;
   wlba_pkg::entry_type                rd_entry;

   logic                               idx_ok;
   logic [AW-1:0]                      idx_addr;
   logic [AW-1:0]                      prev_addr;
   logic [wlba_pkg::MARK_W-1:0]        erase_mark;
   logic                               scan_free;
   logic                               erase_hit;
   logic                               cand;
   logic                               better;
   logic [wlba_pkg::ERASE_W-1:0]       er_new;
   logic [wlba_pkg::MARK_W-1:0]        mk_new;
   logic [IW-1:0]                      csr_ext;

   assign rd_entry = ram_rdata;

   // addressing helpers
   assign idx_ok     = (IW'(req_ff.block_index) < IW'(MAX_BLOCKS));
   assign idx_addr   = AW'(req_ff.block_index);
   assign prev_addr  = req_ff.index_kind ? index_cur_ff : user_cur_ff;
   assign erase_mark = req_ff.index_kind ? wlba_pkg::MARK_INDEX : wlba_pkg::MARK_USER;
   assign csr_ext    = IW'(csr_ff);

   // scan entry evaluation
   assign scan_free = (rd_entry.status == wlba_pkg::ST_FREE);
   assign erase_hit = proc_valid_ff && scan_free && (rd_entry.mark == erase_mark);
   assign er_new    = erase_hit ? rd_entry.erases + 32'd1 : rd_entry.erases;
   assign mk_new    = erase_hit ? wlba_pkg::MARK_NONE : rd_entry.mark;
   assign cand      = proc_valid_ff && scan_free &&
                      (rd_entry.mark != wlba_pkg::MARK_USER) &&
                      (rd_entry.mark != wlba_pkg::MARK_RESERVED);
   assign better    = cand && (!have_ff || (er_new < best_erases_ff));

   // next values of the allocation state
   always_comb begin
      req_in             = req_ff;
      limit_in           = limit_ff;
      scan_addr_in       = scan_addr_ff;
      have_in            = have_ff;
      best_addr_in       = best_addr_ff;
      best_erases_in     = best_erases_ff;
      best_mark_in       = best_mark_ff;
      done_in            = done_ff;
      peak_in            = peak_ff;
      user_cur_in        = user_cur_ff;
      user_cur_valid_in  = user_cur_valid_ff;
      index_cur_in       = index_cur_ff;
      index_cur_valid_in = index_cur_valid_ff;

      if (cmd.load) begin
         req_in       = req_payload;
         limit_in     = (csr_ext > IW'(MAX_BLOCKS)) ? IW'(MAX_BLOCKS) : csr_ext;
         scan_addr_in = '0;
         have_in      = 1'b0;
         done_in      = '0;
      end
      if (cmd.scan_issue) begin
         scan_addr_in = scan_addr_ff + 1'b1;
      end
      // erase of a free block carrying this kind's mark
      if (erase_hit) begin
         done_in = done_ff + 1'b1;
         if (er_new > peak_ff) begin
            peak_in = er_new;
         end
      end
      // lowest count so far, first one wins ties
      if (better) begin
         have_in        = 1'b1;
         best_addr_in   = proc_addr_ff;
         best_erases_in = er_new;
         best_mark_in   = mk_new;
      end
      // pending erase of the chosen block, peak untouched
      if (cmd.finish_best && (best_mark_ff == wlba_pkg::MARK_PENDING)) begin
         best_erases_in = best_erases_ff + 32'd1;
         best_mark_in   = wlba_pkg::MARK_NONE;
         done_in        = done_ff + 1'b1;
      end
      if (cmd.best_write) begin
         if (req_ff.index_kind) begin
            index_cur_in       = best_addr_ff;
            index_cur_valid_in = 1'b1;
         end else begin
            user_cur_in       = best_addr_ff;
            user_cur_valid_in = 1'b1;
         end
      end
   end

   // table write and read port selection
   always_comb begin
      ram_we     = 1'b0;
      ram_waddr  = proc_addr_ff;
      ram_wentry = '{status: rd_entry.status, mark: mk_new, erases: er_new};
      ram_raddr  = scan_addr_ff[AW-1:0];
      if (erase_hit) begin
         ram_we = 1'b1;
      end
      if (cmd.write_item && idx_ok) begin
         ram_we     = 1'b1;
         ram_waddr  = idx_addr;
         ram_wentry = '{status: req_ff.entry_status, mark: req_ff.entry_mark,
                        erases: req_ff.entry_erases};
      end
      if (cmd.prev_write) begin
         ram_we     = 1'b1;
         ram_waddr  = prev_addr;
         ram_wentry = '{status: req_ff.index_kind ? wlba_pkg::ST_INDEX_ALLOC
                                                  : wlba_pkg::ST_USER_ALLOC,
                        mark: rd_entry.mark, erases: rd_entry.erases};
      end
      if (cmd.best_write) begin
         ram_we     = 1'b1;
         ram_waddr  = best_addr_ff;
         ram_wentry = '{status: req_ff.index_kind ? wlba_pkg::ST_INDEX_CUR
                                                  : wlba_pkg::ST_USER_CUR,
                        mark: best_mark_ff, erases: best_erases_ff};
      end
      if (cmd.read_issue) begin
         ram_raddr = idx_addr;
      end
      if (cmd.prev_issue) begin
         ram_raddr = prev_addr;
      end
   end

   // result assembly
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         rsp_in             = '0;
         rsp_in.erases_done = done_ff;
         rsp_in.peak_erases = peak_ff;
         case (cmd.rsp_sel)
            wlba_pkg::RSP_WRITE: begin
               rsp_in.result_block = req_ff.block_index;
               if (idx_ok) begin
                  rsp_in.result_status = req_ff.entry_status;
                  rsp_in.result_mark   = req_ff.entry_mark;
                  rsp_in.result_erases = req_ff.entry_erases;
               end
            end
            wlba_pkg::RSP_READ: begin
               rsp_in.result_block = req_ff.block_index;
               if (idx_ok) begin
                  rsp_in.result_status = rd_entry.status;
                  rsp_in.result_mark   = rd_entry.mark;
                  rsp_in.result_erases = rd_entry.erases;
               end
            end
            wlba_pkg::RSP_ALLOC: begin
               rsp_in.result_block  = wlba_pkg::BLOCK_W'(best_addr_ff);
               rsp_in.result_status = req_ff.index_kind ? wlba_pkg::ST_INDEX_CUR
                                                        : wlba_pkg::ST_USER_CUR;
               rsp_in.result_mark   = best_mark_ff;
               rsp_in.result_erases = best_erases_ff;
               rsp_in.found         = 1'b1;
            end
            default: begin
               rsp_in.result_block = '0;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff             <= wlba_pkg::BLOCKS_IN_USE_RESET;
         proc_valid_ff      <= 1'b0;
         have_ff            <= 1'b0;
         done_ff            <= '0;
         peak_ff            <= '0;
         user_cur_ff        <= '0;
         user_cur_valid_ff  <= 1'b0;
         index_cur_ff       <= '0;
         index_cur_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         proc_valid_ff      <= cmd.scan_issue;
         have_ff            <= have_in;
         done_ff            <= done_in;
         peak_ff            <= peak_in;
         user_cur_ff        <= user_cur_in;
         user_cur_valid_ff  <= user_cur_valid_in;
         index_cur_ff       <= index_cur_in;
         index_cur_valid_ff <= index_cur_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      limit_ff       <= limit_in;
      scan_addr_ff   <= scan_addr_in;
      proc_addr_ff   <= scan_addr_ff[AW-1:0];
      best_addr_ff   <= best_addr_in;
      best_erases_ff <= best_erases_in;
      best_mark_ff   <= best_mark_in;
      rsp_ff         <= rsp_in;
   end

   // block table: status, mark and erase count in one word
   wlba_ram #(
      .WIDTH (wlba_pkg::ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wentry),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign stat.scan_end   = (scan_addr_ff == limit_ff);
   assign stat.have       = have_ff;
   assign stat.prev_valid = req_ff.index_kind ? index_cur_valid_ff : user_cur_valid_ff;
   assign rsp_payload     = rsp_ff;

endmodule

`default_nettype wire

[src/wear_leveling_block_allocator_core.sv]
`default_nettype none

// Flash block allocator with wear leveling. A request is taken when start is high and busy
// is low; every request yields exactly one response, shown for a single cycle with rsp_valid,
// and the receiver cannot hold it off. A write request passes through a write state, a read
// through read-issue and read-data states, an unknown mode through a null state. An allocate
// request walks the first min(blocks_in_use, MAX_BLOCKS) table entries at one entry per cycle
// through the single read port of the block table, erasing free blocks that carry the kind's
// mark and tracking the least-worn candidate; it then answers not found, or else retires the
// previous current block of that kind, if any, and writes the chosen block as current.
// Table entries hold no defined value until written; load every entry in use before the
// first allocate. blocks_in_use may only be written while busy is low and no response is due.
module wear_leveling_block_allocator_core #(
   parameter int MAX_BLOCKS = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire wlba_pkg::req_type             req_payload,
   output logic                               rsp_valid,
   output wlba_pkg::rsp_type                  rsp_payload,
   input  wire logic                          csr_we,
   input  wire logic [wlba_pkg::COUNT_W-1:0]  csr_wdata
);

   wlba_pkg::cmd_type  cmd;
   wlba_pkg::stat_type stat;

   // sequencing
   wlba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_payload.mode),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // table, scan and result datapath
   wlba_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

   // an accepted request always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // returning to idle always comes with a response
   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("request finished without a response");

   // a response follows work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in progress");

   // a found block is reported as the new current block
   a_found_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.found) |->
         (rsp_payload.result_status == wlba_pkg::ST_USER_CUR ||
          rsp_payload.result_status == wlba_pkg::ST_INDEX_CUR))
      else $error("allocated block not marked current");

endmodule

`default_nettype wire

[tb/wear_leveling_block_allocator_checker.sv]
`timescale 1ns / 100ps

module wear_leveling_block_allocator_checker
   import wlba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire req_type             req_payload,
   input  wire logic                rsp_valid,
   input  wire rsp_type             rsp_payload,
   input  wire logic                csr_we,
   input  wire logic [COUNT_W-1:0]  csr_wdata,
   output int                       mismatch_count,
   output int                       pending
);

   localparam int TABLE_DEPTH = 1 << BLOCK_W;
   localparam int PRINT_CAP   = 200;

   // shadow copy of the block table and allocator state
   logic [STATUS_W-1:0] status_of [TABLE_DEPTH];
   logic [MARK_W-1:0]   mark_of   [TABLE_DEPTH];
   logic [ERASE_W-1:0]  wear_of   [TABLE_DEPTH];
   logic [BLOCK_W-1:0]  user_head;
   logic                user_head_ok;
   logic [BLOCK_W-1:0]  index_head;
   logic                index_head_ok;
   logic [ERASE_W-1:0]  peak_wear;
   logic [COUNT_W-1:0]  scan_len;

   rsp_type due_responses [$];

   task automatic report(input string line);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("%0t ns: %s", $time, line);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report($sformatf("response field %s is %0h, expected %0h", name, got, want));
      end
   endtask

   // scan the blocks in use, erase matching free blocks, pick the least worn candidate
   function automatic rsp_type allocate_block(input logic for_index);
      rsp_type             rsp;
      int                  limit;
      int                  b;
      logic [MARK_W-1:0]   wanted_mark;
      logic [MARK_W-1:0]   old_mark;
      logic                have;
      logic [BLOCK_W-1:0]  best;
      logic [ERASE_W-1:0]  best_wear;
      logic [COUNT_W-1:0]  erased;
      rsp = '0;
      limit = (scan_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_len);
      wanted_mark = for_index ? MARK_INDEX : MARK_USER;
      have = 1'b0;
      best = '0;
      best_wear = '0;
      erased = '0;
      for (b = 0; b < limit; b++) begin
         if (status_of[b] != ST_FREE) continue;
         old_mark = mark_of[b];
         if (old_mark == wanted_mark) begin
            mark_of[b] = MARK_NONE;
            wear_of[b] = wear_of[b] + 1'b1;
            erased++;
            if (wear_of[b] > peak_wear) peak_wear = wear_of[b];
         end
         if (old_mark != MARK_USER && old_mark != MARK_RESERVED &&
             (!have || wear_of[b] < best_wear)) begin
            have = 1'b1;
            best = b[BLOCK_W-1:0];
            best_wear = wear_of[b];
         end
      end
      if (have) begin
         // pending erase on the chosen block, peak left alone
         if (mark_of[best] == MARK_PENDING) begin
            wear_of[best] = wear_of[best] + 1'b1;
            mark_of[best] = MARK_NONE;
            erased++;
         end
         if (for_index) begin
            if (index_head_ok) status_of[index_head] = ST_INDEX_ALLOC;
            index_head = best;
            index_head_ok = 1'b1;
            status_of[best] = ST_INDEX_CUR;
         end else begin
            if (user_head_ok) status_of[user_head] = ST_USER_ALLOC;
            user_head = best;
            user_head_ok = 1'b1;
            status_of[best] = ST_USER_CUR;
         end
         rsp.result_block = best;
         rsp.result_status = status_of[best];
         rsp.result_mark = mark_of[best];
         rsp.result_erases = wear_of[best];
         rsp.found = 1'b1;
      end
      rsp.erases_done = erased;
      return rsp;
   endfunction

   // expected response of one request, updating the shadow state
   function automatic rsp_type serve_request(input req_type r);
      rsp_type rsp;
      rsp = '0;
      case (r.mode)
         MODE_WRITE: begin
            status_of[r.block_index] = r.entry_status;
            mark_of[r.block_index] = r.entry_mark;
            wear_of[r.block_index] = r.entry_erases;
            rsp.result_block = r.block_index;
            rsp.result_status = r.entry_status;
            rsp.result_mark = r.entry_mark;
            rsp.result_erases = r.entry_erases;
         end
         MODE_READ: begin
            rsp.result_block = r.block_index;
            rsp.result_status = status_of[r.block_index];
            rsp.result_mark = mark_of[r.block_index];
            rsp.result_erases = wear_of[r.block_index];
         end
         MODE_ALLOC: rsp = allocate_block(r.index_kind);
         default: ;
      endcase
      rsp.peak_erases = peak_wear;
      return rsp;
   endfunction

   // compare responses, track the register, predict accepted requests
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            status_of[i] = ST_FREE;
            mark_of[i] = MARK_NONE;
            wear_of[i] = '0;
         end
         user_head = '0;
         user_head_ok = 1'b0;
         index_head = '0;
         index_head_ok = 1'b0;
         peak_wear = '0;
         scan_len = BLOCKS_IN_USE_RESET;
         due_responses.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (due_responses.size() == 0) begin
               report("response with no request outstanding");
            end else begin
               want = due_responses.pop_front();
               compare_field("result_block", 32'(rsp_payload.result_block),
                             32'(want.result_block));
               compare_field("result_status", 32'(rsp_payload.result_status),
                             32'(want.result_status));
               compare_field("result_mark", 32'(rsp_payload.result_mark),
                             32'(want.result_mark));
               compare_field("result_erases", rsp_payload.result_erases,
                             want.result_erases);
               compare_field("found", 32'(rsp_payload.found), 32'(want.found));
               compare_field("erases_done", 32'(rsp_payload.erases_done),
                             32'(want.erases_done));
               compare_field("peak_erases", rsp_payload.peak_erases, want.peak_erases);
            end
         end
         if (csr_we) scan_len = csr_wdata;
         if (start && !busy) due_responses.push_back(serve_request(req_payload));
      end
      pending = due_responses.size();
   end

endmodule

[tb/tb_wear_leveling_block_allocator_core.sv]
`timescale 1ns / 100ps

module tb_wear_leveling_block_allocator_core;
   import wlba_pkg::*;

   localparam int TABLE_DEPTH    = 1 << BLOCK_W;
   localparam int WATCHDOG_LIMIT = 20000;

   // codes outside the package encodings
   localparam logic [1:0]          MODE_NONE  = 2'd3;
   localparam logic [STATUS_W-1:0] ST_SIX     = 3'd6;
   localparam logic [STATUS_W-1:0] ST_SEVEN   = 3'd7;
   localparam logic [MARK_W-1:0]   MARK_OTHER = 3'd3;
   localparam logic [MARK_W-1:0]   MARK_TOP   = 3'd7;
   localparam logic                KIND_USER  = 1'b0;
   localparam logic                KIND_INDEX = 1'b1;

   // scan lengths
   localparam logic [COUNT_W-1:0]  SCAN_NONE  = '0;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_payload;
   logic                rsp_valid;
   rsp_type             rsp_payload;
   logic                csr_we;
   logic [COUNT_W-1:0]  csr_wdata;
   int                  mismatch_count;
   int                  pending;
   int                  quiet_cycles = 0;

   bit                  written [TABLE_DEPTH];
   int                  scan_limit;
   bit                  burst;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   wear_leveling_block_allocator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   wear_leveling_block_allocator_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   // stop when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or response for %0d cycles", quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_req(input logic [1:0] mode, input int idx,
                                        input logic [STATUS_W-1:0] st,
                                        input logic [MARK_W-1:0] mk,
                                        input logic [ERASE_W-1:0] er, input logic kind);
      req_type r;
      r.mode = mode;
      r.block_index = BLOCK_W'(idx);
      r.entry_status = st;
      r.entry_mark = mk;
      r.entry_erases = er;
      r.index_kind = kind;
      return r;
   endfunction

   function automatic req_type noise_request();
      return make_req(2'($urandom_range(0, 3)), $urandom_range(0, TABLE_DEPTH - 1),
                      STATUS_W'($urandom()), MARK_W'($urandom()), $urandom(),
                      1'($urandom()));
   endfunction

   // entry content weighted toward free blocks and meaningful marks
   function automatic req_type random_write(input int idx);
      logic [STATUS_W-1:0] st;
      logic [MARK_W-1:0]   mk;
      logic [ERASE_W-1:0]  er;
      st = ($urandom_range(0, 9) < 6) ? ST_FREE : STATUS_W'($urandom_range(0, 7));
      case ($urandom_range(0, 6))
         0: mk = MARK_NONE;
         1: mk = MARK_PENDING;
         2: mk = MARK_USER;
         3: mk = MARK_INDEX;
         4: mk = MARK_RESERVED;
         default: mk = MARK_W'($urandom());
      endcase
      case ($urandom_range(0, 4))
         0, 1, 2: er = ERASE_W'($urandom_range(0, 15));
         3: er = '1 - ERASE_W'($urandom_range(0, 3));
         default: er = $urandom();
      endcase
      return make_req(MODE_WRITE, idx, st, mk, er, 1'($urandom()));
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      int      hi;
      r = noise_request();
      pick = $urandom_range(0, 99);
      hi = (scan_limit + 1 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : scan_limit + 1;
      if (pick < 35) begin
         r = random_write(($urandom_range(0, 9) == 0) ? $urandom_range(0, TABLE_DEPTH - 1)
                                                      : $urandom_range(0, hi));
      end else if (pick < 55) begin
         r.mode = MODE_READ;
         r.block_index = BLOCK_W'($urandom_range(0, scan_limit - 1));
      end else if (pick < 90) begin
         r.mode = MODE_ALLOC;
      end else begin
         r.mode = MODE_NONE;
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // present a request and hold it until the block takes it
   task automatic send_req(input req_type r);
      start = 1'b1;
      req_payload = r;
      if (r.mode == MODE_WRITE) written[r.block_index] = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic issue(input req_type r);
      int gap;
      send_req(r);
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         req_payload = noise_request();
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold off until every response is back and the block is idle
   task automatic drain_responses();
      start = 1'b0;
      while (pending != 0 || busy) @(negedge clock);
   endtask

   task automatic set_scan_len(input logic [COUNT_W-1:0] len);
      drain_responses();
      csr_we = 1'b1;
      csr_wdata = len;
      @(negedge clock);
      csr_we = 1'b0;
      csr_wdata = COUNT_W'($urandom());
      scan_limit = (len > TABLE_DEPTH) ? TABLE_DEPTH : int'(len);
   endtask

   // every entry an allocate will scan gets written first
   task automatic fill_in_use();
      for (int i = 0; i < scan_limit; i++) begin
         if (!written[i]) issue(random_write(i));
      end
   endtask

   task automatic random_phase(input logic [COUNT_W-1:0] len, input int count);
      set_scan_len(len);
      burst = ($urandom_range(0, 3) == 0);
      fill_in_use();
      repeat (count) begin
         issue(random_request());
         if ($urandom_range(0, 19) == 0) drain_responses();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      scan_limit = TABLE_DEPTH;
      burst = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // directed: a small table with every mark kind and several status kinds
      set_scan_len(13'd8);
      issue(make_req(MODE_WRITE, 0, ST_FREE, MARK_USER, 32'd5, KIND_USER));
      issue(make_req(MODE_WRITE, 1, ST_FREE, MARK_PENDING, 32'd3, KIND_INDEX));
      issue(make_req(MODE_WRITE, 2, ST_FREE, MARK_RESERVED, 32'd0, KIND_USER));
      issue(make_req(MODE_WRITE, 3, ST_FREE, MARK_INDEX, 32'hFFFF_FFFF, KIND_USER));
      issue(make_req(MODE_WRITE, 4, ST_SIX, MARK_NONE, 32'd0, KIND_USER));
      issue(make_req(MODE_WRITE, 5, ST_SEVEN, MARK_TOP, 32'd1, KIND_INDEX));
      issue(make_req(MODE_WRITE, 6, ST_FREE, MARK_OTHER, 32'd3, KIND_USER));
      issue(make_req(MODE_WRITE, 7, ST_USER_ALLOC, MARK_NONE, 32'd0, KIND_USER));
      // user, index, user, index: previous current blocks get retired
      issue(make_req(MODE_ALLOC, 0, ST_FREE, MARK_NONE, 32'd0, KIND_USER));
      issue(make_req(MODE_ALLOC, 0, ST_FREE, MARK_NONE, 32'd0, KIND_INDEX));
      issue(make_req(MODE_ALLOC, 0, ST_FREE, MARK_NONE, 32'd0, KIND_USER));
      issue(make_req(MODE_ALLOC, 0, ST_FREE, MARK_NONE, 32'd0, KIND_INDEX));
      // no candidate left
      issue(make_req(MODE_ALLOC, 0, ST_FREE, MARK_NONE, 32'd0, KIND_USER));
      issue(make_req(MODE_READ, 1, ST_FREE, MARK_NONE, 32'd0, KIND_USER));
      issue(make_req(MODE_READ, 3, ST_FREE, MARK_NONE, 32'd0, KIND_USER));
      issue(make_req(MODE_READ, 6, ST_FREE, MARK_NONE, 32'd0, KIND_USER));
      issue(make_req(MODE_READ, 0, ST_FREE, MARK_NONE, 32'd0, KIND_USER));
      issue(make_req(MODE_NONE, TABLE_DEPTH - 1, ST_SEVEN, MARK_TOP, 32'hFFFF_FFFF,
                     KIND_INDEX));
      issue(make_req(MODE_WRITE, TABLE_DEPTH - 1, ST_SEVEN, MARK_TOP, 32'hFFFF_FFFF,
                     KIND_INDEX));
      issue(make_req(MODE_READ, TABLE_DEPTH - 1, ST_FREE, MARK_NONE, 32'd0, KIND_INDEX));
      // empty scan
      set_scan_len(SCAN_NONE);
      issue(make_req(MODE_ALLOC, 0, ST_FREE, MARK_NONE, 32'd0, KIND_USER));
      issue(make_req(MODE_ALLOC, 0, ST_FREE, MARK_NONE, 32'd0, KIND_INDEX));

      // random traffic over small tables
      random_phase(13'd1, 20);
      random_phase(13'd5, 30);
      random_phase(13'd16, 35);
      random_phase(COUNT_W'($urandom_range(2, 12)), 30);

      // wind down and give the verdict
      drain_responses();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
